/* design/acpb_pkg.sv */
// Shared types and constants for the anti-aliased circle pixel blender.
// Used by the channel interfaces and the top level; depends on nothing.
package acpb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // Largest radius taken from the radius register; larger written values keep only their low 10 bits.
  localparam logic [9:0]  MaxRadius  = 10'd1023;
  // Pixels at or beyond this column or row are never written.
  localparam int unsigned ScreenSize = 4096;

  // Squared distance shifted left by 16 is at most 45 bits; the root has 23.
  localparam int unsigned SqrtBits = 23;
  localparam int unsigned RemBits  = 2 * SqrtBits;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX   = 3'd0,
    CfgCenterY   = 3'd1,
    CfgRadius    = 3'd2,
    CfgFillRed   = 3'd3,
    CfgFillGreen = 3'd4,
    CfgFillBlue  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  old_red;
    logic [7:0]  old_green;
    logic [7:0]  old_blue;
  } pix_req_t;

  typedef struct packed {
    logic        write_pixel;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [7:0]  new_red;
    logic [7:0]  new_green;
    logic [7:0]  new_blue;
  } pix_res_t;

endpackage

/* design/acpb_if.sv */
// Valid/ready channel interfaces for pixel requests and blended results.
// Depends on acpb_pkg for the payload types.
interface acpb_req_if;
  import acpb_pkg::*;

  logic     valid;
  logic     ready;
  pix_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acpb_res_if;
  import acpb_pkg::*;

  logic     valid;
  logic     ready;
  pix_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/antialiased_circle_pixel_blend.sv */
// Top level of the anti-aliased filled circle pixel blender.
// Depends on acpb_pkg and the channel interfaces in acpb_if.sv.
//
// Usage: pixel requests arrive on pix_i (position and old color) and
// blended results leave on res_o (write flag, position, new color), one
// result for every request, in order. The circle center, radius and fill
// color are set through the write port cfg_we_i/cfg_idx_i/cfg_data_i while
// no request is in flight; writes to unknown indexes are ignored.
// The datapath is a 29-stage pipeline: offset and absolute value, squares,
// sum, a 23-stage bit-per-stage square root, coverage, blend products and
// the output register. One request is taken every cycle while results drain.
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and pix_i.ready drops in the same cycle; nothing is lost or
// repeated, and a bubble in the last stage never blocks the pipeline.
// Reset empties the pipeline and clears all configuration registers to zero.
module antialiased_circle_pixel_blend (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acpb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [acpb_pkg::CfgDataW-1:0]  cfg_data_i,
  acpb_req_if.sink                       pix_i,
  acpb_res_if.source                     res_o
);
  import acpb_pkg::*;

  localparam int unsigned NumStages = SqrtBits + 6;
  localparam int unsigned StSum     = 2;
  localparam int unsigned StCov     = StSum + SqrtBits + 1;
  localparam int unsigned StProd    = StCov + 1;
  localparam int unsigned StOut     = StProd + 1;

  typedef struct packed {
    logic     act;
    pix_req_t pix;
  } side_t;

  logic [13:0] center_x_q, center_y_q;
  logic [9:0]  radius_q;
  logic [7:0]  fill_q [3];

  logic                 adv;
  logic [NumStages-1:0] valid_q;
  side_t                side_q [NumStages-1];

  logic [9:0]  rad_sat;
  logic        act_d;
  logic signed [14:0] dx_d, dy_d;
  logic [13:0] ax_q, ay_q;
  logic [27:0] sqx_q, sqy_q;
  logic [RemBits-1:0]  rem_q  [SqrtBits+1];
  logic [SqrtBits-1:0] root_q [SqrtBits+1];

  logic [17:0]         reach;
  logic [SqrtBits-1:0] diff;
  logic [8:0]          cov_d, cov_q;
  logic                cov_wr_d, cov_wr_q;
  logic [7:0]          old_c [3];
  logic [16:0]         po_q [3];
  logic [16:0]         pf_q [3];
  logic                prod_wr_q;
  logic [16:0]         bsum [3];
  pix_res_t            out_d, out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      fill_q[0]  <= '0;
      fill_q[1]  <= '0;
      fill_q[2]  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCenterX:   center_x_q <= cfg_data_i;
        CfgCenterY:   center_y_q <= cfg_data_i;
        CfgRadius:    radius_q   <= cfg_data_i[9:0];
        CfgFillRed:   fill_q[0]  <= cfg_data_i[7:0];
        CfgFillGreen: fill_q[1]  <= cfg_data_i[7:0];
        CfgFillBlue:  fill_q[2]  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign rad_sat = (radius_q > MaxRadius) ? MaxRadius : radius_q;

  // The pipeline moves as one unless a finished result is waiting.
  assign adv         = !valid_q[StOut] || res_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NumStages-2:0], pix_i.valid};
    end
  end

  // Stage 0: offsets from the center and their magnitudes.
  assign act_d = (rad_sat != '0) && (32'(pix_i.data.pixel_x) < ScreenSize) &&
                 (32'(pix_i.data.pixel_y) < ScreenSize);
  assign dx_d  = $signed({3'b000, pix_i.data.pixel_x}) - $signed({center_x_q[13], center_x_q});
  assign dy_d  = $signed({3'b000, pix_i.data.pixel_y}) - $signed({center_y_q[13], center_y_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{act: act_d, pix: pix_i.data};
      for (int k = 1; k < NumStages - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
      ax_q <= dx_d[14] ? 14'(-dx_d) : dx_d[13:0];
      ay_q <= dy_d[14] ? 14'(-dy_d) : dy_d[13:0];
      sqx_q <= 28'(ax_q) * 28'(ax_q);
      sqy_q <= 28'(ay_q) * 28'(ay_q);
      rem_q[0]  <= {1'b0, 29'(sqx_q) + 29'(sqy_q), 16'b0};
      root_q[0] <= '0;
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  for (genvar i = 0; i < SqrtBits; i++) begin : g_sqrt
    localparam int unsigned Bit = SqrtBits - 1 - i;
    logic [RemBits-1:0]  trial;
    logic                take;
    logic [RemBits-1:0]  rem_d;
    logic [SqrtBits-1:0] root_d;

    always_comb begin
      trial  = (RemBits'(root_q[i]) << (Bit + 1)) | (RemBits'(1) << (2 * Bit));
      take   = rem_q[i] >= trial;
      rem_d  = take ? rem_q[i] - trial : rem_q[i];
      root_d = take ? root_q[i] | (SqrtBits'(1) << Bit) : root_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[i+1]  <= rem_d;
        root_q[i+1] <= root_d;
      end
    end
  end

  // Coverage is radius + 0.5 - distance, clamped to one.
  always_comb begin
    reach    = {rad_sat, 8'd0} + 18'd128;
    diff     = SqrtBits'(reach) - root_q[SqrtBits];
    cov_d    = '0;
    cov_wr_d = 1'b0;
    if (side_q[StCov-1].act && (SqrtBits'(reach) > root_q[SqrtBits])) begin
      cov_wr_d = 1'b1;
      cov_d    = (diff > SqrtBits'(256)) ? 9'd256 : diff[8:0];
    end
  end

  assign old_c[0] = side_q[StProd-1].pix.old_red;
  assign old_c[1] = side_q[StProd-1].pix.old_green;
  assign old_c[2] = side_q[StProd-1].pix.old_blue;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cov_q     <= cov_d;
      cov_wr_q  <= cov_wr_d;
      prod_wr_q <= cov_wr_q;
      for (int c = 0; c < 3; c++) begin
        po_q[c] <= 17'(old_c[c]) * 17'(9'd256 - cov_q);
        pf_q[c] <= 17'(fill_q[c]) * 17'(cov_q);
      end
      out_q <= out_d;
    end
  end

  // Final blend and pass-through selection.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bsum[c] = po_q[c] + pf_q[c];
    end
    out_d.write_pixel = prod_wr_q;
    out_d.out_x       = side_q[StOut-1].pix.pixel_x;
    out_d.out_y       = side_q[StOut-1].pix.pixel_y;
    out_d.new_red     = prod_wr_q ? bsum[0][15:8] : side_q[StOut-1].pix.old_red;
    out_d.new_green   = prod_wr_q ? bsum[1][15:8] : side_q[StOut-1].pix.old_green;
    out_d.new_blue    = prod_wr_q ? bsum[2][15:8] : side_q[StOut-1].pix.old_blue;
  end

  assign res_o.valid = valid_q[StOut];
  assign res_o.data  = out_q;

  // The final remainder of the root never exceeds twice the root.
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StCov-1] |-> rem_q[SqrtBits] <= RemBits'({root_q[SqrtBits], 1'b0}))
    else $error("square root remainder out of range");

  // A written pixel always has coverage between one step and one.
  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StCov] && cov_wr_q |-> cov_q != 9'd0 && cov_q <= 9'd256)
    else $error("coverage out of range for a written pixel");

  // A zero radius never raises the write flag.
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StCov] && radius_q == 10'd0 |-> !cov_wr_q)
    else $error("write flag raised with zero radius");

  // A stall keeps the item ahead of the output register in place.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StOut-1] && !adv |=> valid_q[StOut-1] && valid_q[StOut])
    else $error("pipeline item lost during stall");

endmodule

/* tb/antialiased_circle_pixel_blend_tb.sv */
// Self-checking testbench for the anti-aliased circle pixel blender.
// Depends on acpb_pkg, the channel interfaces in acpb_if.sv and the top level.
// Pixel requests flow through randomly idling channels; each result is checked.
module antialiased_circle_pixel_blend_tb;
  import acpb_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic [CfgIdxW-1:0] CfgUnusedA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedB = 3'd7;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned NumSettings  = 8;
  localparam int unsigned ChunkPixels  = 40;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  acpb_req_if pix_if ();
  acpb_res_if res_if ();

  antialiased_circle_pixel_blend u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  logic signed [13:0] circ_cx;
  logic signed [13:0] circ_cy;
  logic [9:0]         circ_radius;
  logic [7:0]         paint_r;
  logic [7:0]         paint_g;
  logic [7:0]         paint_b;

  pix_req_t    pend_pixels[$];
  pix_res_t    blend_expect[$];
  int unsigned send_gap;
  int unsigned sink_stall;
  bit          steady;
  int unsigned n_checked;
  int unsigned n_written;
  int unsigned n_errors;
  int unsigned n_settings;
  int unsigned quiet_cycles;

  always #5 clk_i = ~clk_i;

  function automatic u64_t root_floor(u64_t n);
    u64_t acc;
    u64_t trial;
    acc = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = acc | (u64_t'(1) << b);
      if (trial * trial <= n) acc = trial;
    end
    return acc;
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] under, logic [7:0] paint,
                                             int unsigned c);
    int unsigned sum;
    sum = under * (256 - c) + paint * c;
    return 8'(sum >> 8);
  endfunction

  function automatic pix_res_t blend_pixel(pix_req_t p);
    pix_res_t r;
    int       dx;
    int       dy;
    u64_t     ax;
    u64_t     ay;
    u64_t     radial;
    u64_t     reach;
    u64_t     cov;
    r.write_pixel = 1'b0;
    r.out_x       = p.pixel_x;
    r.out_y       = p.pixel_y;
    r.new_red     = p.old_red;
    r.new_green   = p.old_green;
    r.new_blue    = p.old_blue;
    if (circ_radius != 0) begin
      dx = int'(p.pixel_x) - int'(circ_cx);
      dy = int'(p.pixel_y) - int'(circ_cy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ax = dx;
      ay = dy;
      radial = root_floor((ax * ax + ay * ay) << 16);
      reach  = {circ_radius, 8'd128};
      if (reach > radial) begin
        cov = reach - radial;
        if (cov > 256) cov = 256;
        r.write_pixel = 1'b1;
        r.new_red     = mix_channel(p.old_red, paint_r, int'(cov));
        r.new_green   = mix_channel(p.old_green, paint_g, int'(cov));
        r.new_blue    = mix_channel(p.old_blue, paint_b, int'(cov));
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  task automatic compare_result(pix_res_t got, pix_res_t want);
    string at;
    at = $sformatf("pixel (%0d,%0d)", want.out_x, want.out_y);
    if (got.write_pixel !== want.write_pixel)
      report($sformatf("%s write_pixel %0d, expected %0d", at, got.write_pixel,
                       want.write_pixel));
    if (got.out_x !== want.out_x)
      report($sformatf("%s out_x %0d, expected %0d", at, got.out_x, want.out_x));
    if (got.out_y !== want.out_y)
      report($sformatf("%s out_y %0d, expected %0d", at, got.out_y, want.out_y));
    if (got.new_red !== want.new_red)
      report($sformatf("%s new_red %0d, expected %0d", at, got.new_red, want.new_red));
    if (got.new_green !== want.new_green)
      report($sformatf("%s new_green %0d, expected %0d", at, got.new_green,
                       want.new_green));
    if (got.new_blue !== want.new_blue)
      report($sformatf("%s new_blue %0d, expected %0d", at, got.new_blue, want.new_blue));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgCenterX:   circ_cx     = val[13:0];
      CfgCenterY:   circ_cy     = val[13:0];
      CfgRadius:    circ_radius = val[9:0];
      CfgFillRed:   paint_r     = val[7:0];
      CfgFillGreen: paint_g     = val[7:0];
      CfgFillBlue:  paint_b     = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic queue_pixel(int x, int y, int unsigned r, int unsigned g, int unsigned b);
    pix_req_t q;
    q.pixel_x   = x[11:0];
    q.pixel_y   = y[11:0];
    q.old_red   = r[7:0];
    q.old_green = g[7:0];
    q.old_blue  = b[7:0];
    pend_pixels.push_back(q);
  endtask

  task automatic drain();
    while (pend_pixels.size() != 0 || blend_expect.size() != 0 || pix_if.valid)
      @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) blend_expect.push_back(blend_pixel(pix_if.data));
      if (!pix_if.valid || pix_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_if.valid <= 1'b0;
        end else if (pend_pixels.size() > 0) begin
          pix_if.data  <= pend_pixels.pop_front();
          pix_if.valid <= 1'b1;
          send_gap = idle_len();
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (blend_expect.size() == 0) begin
          report($sformatf("result for pixel (%0d,%0d) with no request outstanding",
                           res_if.data.out_x, res_if.data.out_y));
        end else begin
          compare_result(res_if.data, blend_expect.pop_front());
          n_checked++;
          if (res_if.data.write_pixel) n_written++;
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res_if.ready <= 1'b0;
      end else begin
        sink_stall = ($urandom_range(0, 9) == 0) ? idle_len() : 0;
        res_if.ready <= (sink_stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (pix_if.valid && pix_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no request or result moved for %0d cycles", QuietLimit);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          cx;
    int          cy;
    int          px;
    int          py;
    int unsigned span;
    int unsigned roll;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    res_if.ready = 1'b0;
    circ_cx      = '0;
    circ_cy      = '0;
    circ_radius  = '0;
    paint_r      = '0;
    paint_g      = '0;
    paint_b      = '0;
    steady       = 1'b0;
    n_checked    = 0;
    n_written    = 0;
    n_errors     = 0;
    n_settings   = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the reset radius of zero nothing is covered.
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(4095, 4095, 255, 255, 255);
    queue_pixel(2048, 1365, 170, 85, 1);
    drain();

    write_reg(CfgCenterX, 14'd100);
    write_reg(CfgCenterY, 14'd100);
    write_reg(CfgRadius, 14'd10);
    write_reg(CfgFillRed, 14'd255);
    write_reg(CfgFillGreen, 14'd0);
    write_reg(CfgFillBlue, 14'd128);
    queue_pixel(100, 100, 0, 255, 77);
    queue_pixel(110, 100, 255, 255, 0);
    queue_pixel(107, 107, 0, 0, 255);
    queue_pixel(100, 90, 128, 64, 32);
    queue_pixel(111, 100, 12, 34, 56);
    queue_pixel(100, 111, 255, 0, 255);
    drain();

    // Writes to unused indexes must leave every register unchanged.
    write_reg(CfgUnusedA, 14'h3FFF);
    write_reg(CfgUnusedB, 14'h2AAA);
    queue_pixel(100, 100, 0, 0, 0);
    drain();
    write_reg(CfgRadius, 14'd1);
    drain();
    queue_pixel(100, 100, 9, 9, 9);
    queue_pixel(101, 100, 200, 100, 50);
    queue_pixel(101, 101, 255, 255, 255);
    drain();

    // A center far off screen leaves every on-screen pixel uncovered.
    write_reg(CfgCenterX, 14'h3000);
    write_reg(CfgCenterY, 14'h1FFF);
    write_reg(CfgRadius, 14'd1023);
    queue_pixel(0, 4095, 1, 2, 3);
    queue_pixel(4095, 4095, 250, 251, 252);
    drain();

    write_reg(CfgCenterX, 14'd0);
    write_reg(CfgCenterY, 14'd0);
    write_reg(CfgFillRed, 14'd0);
    write_reg(CfgFillGreen, 14'h3FFF);
    write_reg(CfgFillBlue, 14'd0);
    queue_pixel(0, 0, 255, 0, 255);
    queue_pixel(1023, 0, 255, 0, 255);
    queue_pixel(0, 1024, 77, 88, 99);
    queue_pixel(723, 723, 0, 0, 0);
    queue_pixel(4095, 0, 255, 255, 255);
    drain();
    n_settings = 5;

    for (int ph = 0; ph < NumSettings; ph++) begin
      steady = (ph % 4 == 3);
      if (ph == 0) begin
        write_reg(CfgCenterX, 14'd0);
        write_reg(CfgCenterY, 14'd4095);
        write_reg(CfgRadius, 14'd1023);
        write_reg(CfgFillRed, 14'd255);
        write_reg(CfgFillGreen, 14'd255);
        write_reg(CfgFillBlue, 14'd255);
      end else if (ph == 1) begin
        write_reg(CfgCenterX, 14'd4095);
        write_reg(CfgCenterY, 14'd4095);
        write_reg(CfgRadius, 14'd1);
        write_reg(CfgFillRed, 14'd0);
        write_reg(CfgFillGreen, 14'd0);
        write_reg(CfgFillBlue, 14'd0);
      end else begin
        cx = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 12287)) - 4096
                                           : int'($urandom_range(0, 4095));
        cy = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 12287)) - 4096
                                           : int'($urandom_range(0, 4095));
        write_reg(CfgCenterX, cx[13:0]);
        write_reg(CfgCenterY, cy[13:0]);
        roll = $urandom_range(0, 99);
        if (roll < 10) write_reg(CfgRadius, 14'd0);
        else if (roll < 20) write_reg(CfgRadius, 14'd1023);
        else if (roll < 40) write_reg(CfgRadius, 14'($urandom_range(1, 3)));
        else if (roll < 50) write_reg(CfgRadius, 14'($urandom));
        else write_reg(CfgRadius, 14'($urandom_range(4, 60)));
        write_reg(CfgFillRed, ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom % 256));
        write_reg(CfgFillGreen, 14'($urandom));
        write_reg(CfgFillBlue, 14'($urandom % 256));
      end
      n_settings++;
      // Each setting is sent in two bursts; the sender waits for every
      // result of the first burst before starting the second.
      for (int chunk = 0; chunk < 2; chunk++) begin
        for (int i = 0; i < ChunkPixels; i++) begin
          if ($urandom_range(0, 99) < 75) begin
            span = int'(circ_radius) + 2;
            px = int'(circ_cx) + int'($urandom_range(0, 2 * span)) - int'(span);
            py = int'(circ_cy) + int'($urandom_range(0, 2 * span)) - int'(span);
            if (px < 0) px = 0;
            if (px > 4095) px = 4095;
            if (py < 0) py = 0;
            if (py > 4095) py = 4095;
          end else begin
            px = int'($urandom_range(0, 4095));
            py = int'($urandom_range(0, 4095));
          end
          queue_pixel(px, py, $urandom % 256, $urandom % 256, $urandom % 256);
        end
        drain();
      end
    end

    steady = 1'b0;
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (blend_expect.size() != 0)
      report($sformatf("%0d results never arrived", blend_expect.size()));
    $display("Summary: %0d pixel results checked, %0d rewritten, over %0d circle settings",
             n_checked, n_written, n_settings);
    $display("Summary: zero radius, full and edge coverage, far-off centers, unused writes");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/acpb_pkg.sv
design/acpb_if.sv
design/antialiased_circle_pixel_blend.sv
tb/antialiased_circle_pixel_blend_tb.sv
